### hw/rtl/quadrature_distance_speed_meter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature distance and speed meter
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DISTANCE_SPEED_METER_TOP_MACROS_SVH
`define QUADRATURE_DISTANCE_SPEED_METER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QDSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QDSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/qdsm_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature distance and speed meter package
// Widths, codes and the request and response types of the divider.
// ----------------------------------------------------------------------------
package qdsm_pkg;

  localparam int PPC_W       = 16;
  localparam int FRAC_BITS   = 8;
  localparam int TIME_W      = 32;
  localparam int DATA_W      = 32;
  localparam int MAG_W       = 32;
  localparam int K_W         = 22;
  localparam int NUM_W       = MAG_W + K_W;
  localparam int DEN_W       = PPC_W + TIME_W;
  localparam int CNT_W       = $clog2(MAG_W);
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (3 * DATA_W + 2);
  localparam int CFG_IDX_W   = 1;

  localparam logic [K_W-1:0]   K_DIST    = K_W'(1 << FRAC_BITS);
  localparam logic [K_W-1:0]   K_SPEED   = K_W'(10000 << FRAC_BITS);
  localparam logic [PPC_W-1:0] PPC_RESET = PPC_W'(256);

  typedef enum logic [2:0] {
    OP_SAMPLE     = 3'd0,
    OP_RESET_ALL  = 3'd1,
    OP_RESET_DIST = 3'd2,
    OP_SPEED      = 3'd3,
    OP_CAPTURE    = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PPC = 1'b0,
    REG_CAL = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MUL,
    DV_CHK,
    DV_RUN,
    DV_FIN
  } div_state_e;

  typedef struct packed {
    logic              start;
    logic              ack;
    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [K_W-1:0]    k;
    logic [PPC_W-1:0]  ppc;
    logic [TIME_W-1:0] dt;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] quo;
  } div_rsp_t;

endpackage

### hw/rtl/qdsm_div.sv
// ----------------------------------------------------------------------------
// Scaled divider
// Computes sign * mag * k / (ppc * dt), truncated and saturated to 32 bits,
// one quotient bit per cycle through a shared remainder and shift register.
// ----------------------------------------------------------------------------
module qdsm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qdsm_pkg::div_req_t req_i,
  output qdsm_pkg::div_rsp_t rsp_o
);
  import qdsm_pkg::*;

  div_state_e        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              neg_q;
  logic              sat_q;
  logic [MAG_W-1:0]  mag_q;
  logic [K_W-1:0]    k_q;
  logic [PPC_W-1:0]  ppc_q;
  logic [TIME_W-1:0] dt_q;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [MAG_W-1:0]  sh_q;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;
  logic [K_W-1:0]    num_hi;
  logic              over;
  logic [DATA_W-1:0] quo;

  assign trial  = {rem_q, sh_q[MAG_W-1]};
  assign diff   = trial - {1'b0, den_q};
  assign fits   = trial >= {1'b0, den_q};
  assign num_hi = num_q[NUM_W-1:MAG_W];
  assign over   = {{(DEN_W - K_W){1'b0}}, num_hi} >= den_q;

  always_comb begin
    if (!neg_q) begin
      quo = (sat_q || sh_q[MAG_W-1]) ? 32'h7FFF_FFFF : sh_q;
    end else if (sat_q || (sh_q[MAG_W-1] && (sh_q[MAG_W-2:0] != '0))) begin
      quo = 32'h8000_0000;
    end else begin
      quo = ~sh_q + 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rsp_o   = '0;
    rsp_o.busy = (state_q != DV_IDLE);
    rsp_o.quo  = quo;
    unique case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          state_d = DV_MUL;
        end
      end
      DV_MUL: begin
        state_d = DV_CHK;
      end
      DV_CHK: begin
        cnt_d   = '0;
        state_d = over ? DV_FIN : DV_RUN;
      end
      DV_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MAG_W - 1)) begin
          state_d = DV_FIN;
        end
      end
      DV_FIN: begin
        rsp_o.done = 1'b1;
        if (req_i.ack) begin
          state_d = DV_IDLE;
        end
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DV_IDLE && req_i.start) begin
      neg_q <= req_i.neg;
      mag_q <= req_i.mag;
      k_q   <= req_i.k;
      ppc_q <= req_i.ppc;
      dt_q  <= req_i.dt;
    end
    if (state_q == DV_MUL) begin
      num_q <= NUM_W'(mag_q) * NUM_W'(k_q);
      den_q <= DEN_W'(ppc_q) * DEN_W'(dt_q);
    end
    if (state_q == DV_CHK) begin
      sat_q <= over;
      rem_q <= {{(DEN_W - K_W){1'b0}}, num_hi};
      sh_q  <= num_q[MAG_W-1:0];
    end
    if (state_q == DV_RUN) begin
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh_q  <= {sh_q[MAG_W-2:0], fits};
    end
  end

endmodule

### hw/rtl/quadrature_distance_speed_meter_top.sv
// ----------------------------------------------------------------------------
// Quadrature distance and speed meter
// Decodes encoder samples and reports position, distance and speed.
// ----------------------------------------------------------------------------
// Each input word carries one command: a sample of the encoder lines, a reset
// of all counters, a reset of the distance, a speed request or a capture of
// the initial A level. Every accepted word yields exactly one result word.
// Commands that need no division give their result in the cycle after the
// accepting edge and can follow back to back while the receiver keeps up.
// A count step with calibration on and a nonzero ratio, and a speed request
// with elapsed time and a nonzero ratio, give their result through the
// divider, which retires one quotient bit per cycle after a multiply step
// and an overflow check; a quotient overflow skips the bit loop. One word
// is worked on at a time, so the next word can be taken at the earliest in
// the cycle in which the last result appears. A result waiting in the output
// register holds off the input until the receiver takes it, and a finished
// division waits for the output register. Reset clears all counters and
// references and loads the pulses per centimetre register with 256 and
// calibration off. Configuration writes take effect at once.
// ----------------------------------------------------------------------------
`include "quadrature_distance_speed_meter_top_macros.svh"

module quadrature_distance_speed_meter_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // operation[2:0], a_level[3], b_level[4], switch_level[5], now_ms[37:6]
  input  logic [qdsm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // position_count[31:0], distance_cm[63:32], speed_mm_s[95:64],
  // speed_error[96], button_pressed[97]
  output logic [qdsm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_we_i,
  input  logic [qdsm_pkg::CFG_IDX_W-1:0]       cfg_addr_i,
  input  logic [qdsm_pkg::PPC_W-1:0]           cfg_wdata_i
);
  import qdsm_pkg::*;

  function automatic logic [MAG_W-1:0] mag_of(logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  state_e            state_q, state_d;
  logic [PPC_W-1:0]  ppc_q;
  logic              cal_q;
  logic [DATA_W-1:0] count_q, count_d;
  logic [DATA_W-1:0] dist_q, dist_d;
  logic              prev_a_q, prev_a_d;
  logic [DATA_W-1:0] cref_q, cref_d;
  logic [TIME_W-1:0] tref_q, tref_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_pos_q, out_pos_d;
  logic [DATA_W-1:0] out_dist_q, out_dist_d;
  logic [DATA_W-1:0] out_speed_q, out_speed_d;
  logic              out_err_q, out_err_d;
  logic              out_btn_q, out_btn_d;

  logic [DATA_W-1:0] hold_pos_q, hold_pos_d;
  logic              hold_btn_q, hold_btn_d;
  logic              hold_spd_q, hold_spd_d;

  op_e               op;
  logic              a_lvl, b_lvl, sw_lvl;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] dt;
  logic [DATA_W-1:0] step_cnt;
  logic [DATA_W-1:0] ref_diff;
  logic              out_free;
  logic              in_accept;
  logic              use_div;
  logic              err;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign op       = op_e'(s_axis_tdata[2:0]);
  assign a_lvl    = s_axis_tdata[3];
  assign b_lvl    = s_axis_tdata[4];
  assign sw_lvl   = s_axis_tdata[5];
  assign now      = s_axis_tdata[37:6];
  assign dt       = now - tref_q;
  assign step_cnt = (b_lvl != a_lvl) ? count_q + 1'b1 : count_q - 1'b1;
  assign ref_diff = count_q - cref_q;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_btn_q, out_err_q,
                          out_speed_q, out_dist_q, out_pos_q};

  qdsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    dist_d      = dist_q;
    prev_a_d    = prev_a_q;
    cref_d      = cref_q;
    tref_d      = tref_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_pos_d   = out_pos_q;
    out_dist_d  = out_dist_q;
    out_speed_d = out_speed_q;
    out_err_d   = out_err_q;
    out_btn_d   = out_btn_q;
    hold_pos_d  = hold_pos_q;
    hold_btn_d  = hold_btn_q;
    hold_spd_d  = hold_spd_q;
    use_div     = 1'b0;
    err         = 1'b0;
    div_req     = '0;
    div_req.ppc = ppc_q;
    div_req.dt  = TIME_W'(1);
    div_req.k   = K_DIST;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (op)
            OP_SAMPLE: begin
              if (a_lvl != prev_a_q) begin
                count_d  = step_cnt;
                prev_a_d = a_lvl;
                if (cal_q && (ppc_q != '0)) begin
                  use_div     = 1'b1;
                  div_req.neg = step_cnt[DATA_W-1];
                  div_req.mag = mag_of(step_cnt);
                end
              end
            end
            OP_RESET_ALL: begin
              count_d = '0;
              dist_d  = '0;
              cref_d  = '0;
              tref_d  = now;
            end
            OP_RESET_DIST: begin
              count_d = '0;
              dist_d  = '0;
            end
            OP_SPEED: begin
              err = (ppc_q == '0);
              if (dt != '0) begin
                tref_d = now;
                cref_d = count_q;
                if (!err) begin
                  use_div     = 1'b1;
                  div_req.neg = ref_diff[DATA_W-1];
                  div_req.mag = mag_of(ref_diff);
                  div_req.k   = K_SPEED;
                  div_req.dt  = dt;
                end
              end
            end
            OP_CAPTURE: begin
              prev_a_d = a_lvl;
            end
            default: begin
            end
          endcase
          div_req.start = use_div;
          if (use_div) begin
            state_d    = ST_BUSY;
            hold_pos_d = count_d;
            hold_btn_d = !sw_lvl;
            hold_spd_d = (op == OP_SPEED);
          end else begin
            out_valid_d = 1'b1;
            out_pos_d   = count_d;
            out_dist_d  = dist_d;
            out_speed_d = '0;
            out_err_d   = err;
            out_btn_d   = !sw_lvl;
          end
        end
      end
      ST_BUSY: begin
        if (div_rsp.done && out_free) begin
          div_req.ack = 1'b1;
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_pos_d   = hold_pos_q;
          out_err_d   = 1'b0;
          out_btn_d   = hold_btn_q;
          if (hold_spd_q) begin
            out_speed_d = div_rsp.quo;
            out_dist_d  = dist_q;
          end else begin
            dist_d      = div_rsp.quo;
            out_speed_d = '0;
            out_dist_d  = div_rsp.quo;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dist_q      <= '0;
      prev_a_q    <= 1'b0;
      cref_q      <= '0;
      tref_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      dist_q      <= dist_d;
      prev_a_q    <= prev_a_d;
      cref_q      <= cref_d;
      tref_q      <= tref_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppc_q <= PPC_RESET;
      cal_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_PPC: ppc_q <= cfg_wdata_i;
        REG_CAL: cal_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    out_pos_q   <= out_pos_d;
    out_dist_q  <= out_dist_d;
    out_speed_q <= out_speed_d;
    out_err_q   <= out_err_d;
    out_btn_q   <= out_btn_d;
    hold_pos_q  <= hold_pos_d;
    hold_btn_q  <= hold_btn_d;
    hold_spd_q  <= hold_spd_d;
  end

  `QDSM_ASSERT_SAME(a_div_in_busy, div_rsp.busy, state_q == ST_BUSY,
                    "divider active while controller idle")
  `QDSM_ASSERT_NEXT(a_reset_all_clears, in_accept && (op == OP_RESET_ALL),
                    (count_q == '0) && (dist_q == '0) && (cref_q == '0),
                    "reset all left state behind")
  `QDSM_ASSERT_SAME(a_err_speed_zero, out_valid_q && out_err_q, out_speed_q == '0,
                    "speed error with nonzero speed")
  `QDSM_ASSERT_NEXT(a_done_loads, (state_q == ST_BUSY) && div_rsp.done && out_free,
                    out_valid_q && (state_q == ST_IDLE),
                    "finished division not delivered")

endmodule
